[sv/bta_pkg.sv]
`default_nettype none

package bta_pkg;

  localparam int HeapSlotsDef = 4096;
  localparam int MinChunk = 32;
  localparam int WantW = 17;
  localparam int AddrW = 15;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk  = 2'd0,
    StOom = 2'd1,
    StOob = 2'd2,
    StDbl = 2'd3
  } status_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] request_size;
    logic [15:0] payload_offset;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] address;
  } out_item_t;

endpackage

`default_nettype wire

[sv/boundary_tag_heap_allocator.sv]
// First-fit heap allocator with boundary tags over HeapSlots slots of 8 bytes, kept in one
// synchronous memory with one read and one write port. After reset the block writes the initial
// free chunk and accepts no item until that is done. A free out of bounds is answered without
// touching the heap, a double free after reading the chunk header, and any other free after
// merging with its free neighbours and relinking the free list. An allocation reads the header
// and then the link of each free chunk it passes over on the list walk, and ends with an
// out-of-memory result when the walk finds no fit, or else takes an exact fit or splits a chunk.
// One item is worked on at a time; a result waits in an output register while the next item
// proceeds, and a second result waits in the controller until that register is free.
`default_nettype none

module boundary_tag_heap_allocator #(
  parameter int HeapSlots = bta_pkg::HeapSlotsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire bta_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output bta_pkg::out_item_t      out_item_o
);
  import bta_pkg::*;

  localparam int AW = $clog2(HeapSlots);
  localparam int LW = $clog2(HeapSlots + 1);
  localparam int W = LW + 3;
  localparam int XW = AW + 3;

  logic          mem_we, mem_re;
  logic [XW-1:0] mem_waddr, mem_raddr;
  logic [W-1:0]  mem_wdata, mem_rdata;
  logic          res_valid, res_ready;
  out_item_t     res_item;
  logic          out_valid_q;
  out_item_t     out_item_q;

  bta_ctrl #(.HeapSlots(HeapSlots)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bta_mem #(.HeapSlots(HeapSlots)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

[sv/bta_mem.sv]
`default_nettype none

module bta_mem #(
  parameter int HeapSlots = bta_pkg::HeapSlotsDef,
  localparam int AW = $clog2(HeapSlots),
  localparam int LW = $clog2(HeapSlots + 1),
  localparam int W = LW + 3,
  localparam int XW = AW + 3
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [XW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_i,
  input  wire logic [XW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);
  import bta_pkg::*;

  logic [W-1:0] mem_q [HeapSlots];
  logic [W-1:0] rdata_q;
  logic         rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i < XW'(HeapSlots))) begin
      mem_q[waddr_i[AW-1:0]] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i[AW-1:0]];
      rvld_q  <= raddr_i < XW'(HeapSlots);
    end
  end

  // Reads outside the heap return zero.
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

[sv/bta_ctrl.sv]
`default_nettype none

module bta_ctrl #(
  parameter int HeapSlots = bta_pkg::HeapSlotsDef,
  localparam int AW = $clog2(HeapSlots),
  localparam int LW = $clog2(HeapSlots + 1),
  localparam int W = LW + 3,
  localparam int XW = AW + 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire bta_pkg::in_item_t   in_item_i,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output bta_pkg::out_item_t       res_item_o,
  output logic                     mem_we_o,
  output logic [XW-1:0]            mem_waddr_o,
  output logic [W-1:0]             mem_wdata_o,
  output logic                     mem_re_o,
  output logic [XW-1:0]            mem_raddr_o,
  input  wire logic [W-1:0]        mem_rdata_i
);
  import bta_pkg::*;

  localparam int CW = ((W > WantW) ? W : WantW) + 1;
  localparam int OW = ((AW + 4) > AddrW) ? (AW + 4) : AddrW;
  localparam logic [W-1:0] HeapHdr = W'(HeapSlots * 8 + 1);
  localparam logic [LW-1:0] NilLink = LW'(HeapSlots);

  typedef enum logic [26:0] {
    SInit = 27'd1 << 0,
    SIdle = 27'd1 << 1,
    SAHdr = 27'd1 << 2,
    SAChk = 27'd1 << 3,
    SALnk = 27'd1 << 4,
    SAFix = 27'd1 << 5,
    SAExW = 27'd1 << 6,
    SARFt = 27'd1 << 7,
    SACur = 27'd1 << 8,
    SFChk = 27'd1 << 9,
    SFNx  = 27'd1 << 10,
    SFFt  = 27'd1 << 11,
    SFPh  = 27'd1 << 12,
    SFSum = 27'd1 << 13,
    SFHw  = 27'd1 << 14,
    SFFw  = 27'd1 << 15,
    SFPu  = 27'd1 << 16,
    SFNf  = 27'd1 << 17,
    SURp  = 27'd1 << 18,
    SURx  = 27'd1 << 19,
    SUWp  = 27'd1 << 20,
    SUWx  = 27'd1 << 21,
    SPW1  = 27'd1 << 22,
    SPW2  = 27'd1 << 23,
    SPW3  = 27'd1 << 24,
    SDone = 27'd1 << 25,
    SARHw = 27'd1 << 26
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [1:0]       init_q, init_d;
  logic [LW-1:0]    head_q, head_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic             curv_q, curv_d;
  logic [LW-1:0]    steps_q, steps_d;
  logic [WantW-1:0] want_q, want_d;
  logic             ex_q, ex_d;
  logic [W-1:0]     hdr_q, hdr_d;
  logic [AW-1:0]    s_q, s_d;
  logic [XW-1:0]    nx_q, nx_d;
  logic             nxin_q, nxin_d;
  logic [W-1:0]     nxhdr_q, nxhdr_d;
  logic [XW-1:0]    prv_q, prv_d;
  logic [W-1:0]     prvhdr_q, prvhdr_d;
  logic             wp_q, wp_d, wn_q, wn_d;
  logic [W-1:0]     nsz_q, nsz_d;
  logic [XW-1:0]    base_q, base_d, foot_q, foot_d;
  logic [XW-1:0]    n_q, n_d;
  logic [LW-1:0]    lp_q, lp_d, lx_q, lx_d;
  status_e          status_q, status_d;
  logic [AddrW-1:0] addr_q, addr_d;

  logic [WantW-1:0] wsum, want_raw, want_calc;
  logic [CW-1:0]    fsz_rd, fsz_hd, want_c;
  logic [W-1:0]     fsz_w, rsz, psz, sz, nxsz;
  logic [CW-1:0]    rem_w;
  logic [OW-1:0]    addr_w;
  logic [AW-1:0]    s_calc;

  assign wsum      = {1'b0, in_item_i.request_size} + WantW'(15);
  assign want_raw  = {wsum[WantW-1:3], 3'b000};
  assign want_calc = (want_raw < WantW'(MinChunk)) ? WantW'(MinChunk) : want_raw;
  assign s_calc    = AW'(in_item_i.payload_offset[15:3] - 13'd1);
  assign fsz_rd    = CW'({mem_rdata_i[W-1:3], 3'b000});
  assign fsz_w     = {hdr_q[W-1:3], 3'b000};
  assign fsz_hd    = CW'(fsz_w);
  assign want_c    = CW'(want_q);
  assign rsz       = W'(fsz_hd - want_c);
  assign rem_w     = CW'(cur_q) + CW'(want_q[WantW-1:3]);
  assign addr_w    = OW'({cur_q, 3'b000}) + OW'(8);
  assign sz        = fsz_w;
  assign psz       = {prvhdr_q[W-1:3], 3'b000};
  assign nxsz      = {nxhdr_q[W-1:3], 3'b000};

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    init_d   = init_q;
    head_d   = head_q;
    cur_d    = cur_q;
    curv_d   = curv_q;
    steps_d  = steps_q;
    want_d   = want_q;
    ex_d     = ex_q;
    hdr_d    = hdr_q;
    s_d      = s_q;
    nx_d     = nx_q;
    nxin_d   = nxin_q;
    nxhdr_d  = nxhdr_q;
    prv_d    = prv_q;
    prvhdr_d = prvhdr_q;
    wp_d     = wp_q;
    wn_d     = wn_q;
    nsz_d    = nsz_q;
    base_d   = base_q;
    foot_d   = foot_q;
    n_d      = n_q;
    lp_d     = lp_q;
    lx_d     = lx_q;
    status_d = status_q;
    addr_d   = addr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    res_valid_o = 1'b0;
    case (state_q)
      SInit: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = XW'(init_q);
        mem_wdata_o = (init_q == 2'd0) ? HeapHdr : W'(NilLink);
        init_d      = init_q + 2'd1;
        if (init_q == 2'd2) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          addr_d = '0;
          if (in_item_i.operation == OpAlloc) begin
            want_d  = want_calc;
            cur_d   = AW'(head_q);
            curv_d  = head_q < NilLink;
            steps_d = '0;
            state_d = SAHdr;
          end else if ((in_item_i.payload_offset < 16'd8) ||
                       (32'(in_item_i.payload_offset) >= HeapSlots * 8)) begin
            status_d = StOob;
            state_d  = SDone;
          end else begin
            s_d         = s_calc;
            mem_re_o    = 1'b1;
            mem_raddr_o = XW'(s_calc);
            state_d     = SFChk;
          end
        end
      end
      SAHdr: begin
        if (!curv_q || (steps_q == NilLink)) begin
          status_d = StOom;
          state_d  = SDone;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = XW'(cur_q);
          state_d     = SAChk;
        end
      end
      SAChk: begin
        hdr_d = mem_rdata_i;
        ex_d  = fsz_rd == want_c;
        if ((fsz_rd == want_c) || (fsz_rd >= want_c + CW'(MinChunk))) begin
          n_d     = XW'(cur_q);
          ret_d   = SAFix;
          state_d = SURp;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = XW'(cur_q) + XW'(2);
          state_d     = SALnk;
        end
      end
      SALnk: begin
        curv_d  = mem_rdata_i < W'(HeapSlots);
        cur_d   = AW'(mem_rdata_i);
        steps_d = steps_q + LW'(1);
        state_d = SAHdr;
      end
      SAFix: begin
        if (ex_q) begin
          nx_d = XW'(cur_q) + XW'(fsz_w[W-1:3]);
          if ((XW'(cur_q) + XW'(fsz_w[W-1:3])) < XW'(HeapSlots)) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = XW'(cur_q) + XW'(fsz_w[W-1:3]);
            state_d     = SAExW;
          end else begin
            state_d = SACur;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = XW'(rem_w);
          n_d         = XW'(rem_w);
          state_d     = SARHw;
        end
      end
      SARHw: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = n_q;
        mem_wdata_o = (mem_rdata_i & W'(4)) | rsz | W'(1);
        ret_d       = SARFt;
        state_d     = SPW1;
      end
      SAExW: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = nx_q;
        mem_wdata_o = mem_rdata_i & ~W'(2);
        state_d     = SACur;
      end
      SARFt: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = XW'(cur_q) + XW'(fsz_w[W-1:3]) - XW'(1);
        mem_wdata_o = rsz;
        state_d     = SACur;
      end
      SACur: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = XW'(cur_q);
        mem_wdata_o = (hdr_q & W'(6)) | W'(want_q);
        status_d    = StOk;
        addr_d      = addr_w[AddrW-1:0];
        state_d     = SDone;
      end
      SFChk: begin
        hdr_d = mem_rdata_i;
        wp_d  = mem_rdata_i[1];
        nx_d  = XW'(s_q) + XW'(mem_rdata_i[W-1:3]);
        if (mem_rdata_i[0]) begin
          status_d = StDbl;
          state_d  = SDone;
        end else begin
          nxin_d = (XW'(s_q) + XW'(mem_rdata_i[W-1:3])) < XW'(HeapSlots);
          if ((XW'(s_q) + XW'(mem_rdata_i[W-1:3])) < XW'(HeapSlots)) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = XW'(s_q) + XW'(mem_rdata_i[W-1:3]);
          end
          state_d = SFNx;
        end
      end
      SFNx: begin
        nxhdr_d = nxin_q ? mem_rdata_i : '0;
        wn_d    = nxin_q && mem_rdata_i[0];
        if (wp_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = XW'(s_q) - XW'(1);
          state_d     = SFFt;
        end else begin
          state_d = SFSum;
        end
      end
      SFFt: begin
        prv_d       = XW'(s_q) - XW'(mem_rdata_i[W-1:3]);
        mem_re_o    = 1'b1;
        mem_raddr_o = XW'(s_q) - XW'(mem_rdata_i[W-1:3]);
        state_d     = SFPh;
      end
      SFPh: begin
        prvhdr_d = mem_rdata_i;
        state_d  = SFSum;
      end
      SFSum: begin
        nsz_d  = (wp_q ? psz : '0) + sz + (wn_q ? nxsz : '0);
        base_d = wp_q ? prv_q : XW'(s_q);
        foot_d = wn_q ? (nx_q + XW'(nxsz[W-1:3]) - XW'(1)) : (nx_q - XW'(1));
        state_d = SFHw;
      end
      SFHw: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = base_q;
        mem_wdata_o = ((wp_q ? prvhdr_q : hdr_q) & W'(7)) | nsz_q | W'(1);
        state_d     = SFFw;
      end
      SFFw: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = foot_q;
        mem_wdata_o = nsz_q;
        if (wn_q) begin
          n_d     = nx_q;
          ret_d   = SFPu;
          state_d = SURp;
        end else begin
          state_d = SFPu;
        end
      end
      SFPu: begin
        if (!wp_q) begin
          n_d     = XW'(s_q);
          ret_d   = SFNf;
          state_d = SPW1;
        end else begin
          state_d = SFNf;
        end
      end
      SFNf: begin
        if (!wn_q && nxin_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = nx_q;
          mem_wdata_o = nxhdr_q | W'(2);
        end
        status_d = StOk;
        state_d  = SDone;
      end
      SURp: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = n_q + XW'(1);
        state_d     = SURx;
      end
      SURx: begin
        lp_d        = LW'(mem_rdata_i);
        mem_re_o    = 1'b1;
        mem_raddr_o = n_q + XW'(2);
        state_d     = SUWp;
      end
      SUWp: begin
        lx_d = LW'(mem_rdata_i);
        if (lp_q != NilLink) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = XW'(lp_q) + XW'(2);
          mem_wdata_o = W'(LW'(mem_rdata_i));
        end
        state_d = SUWx;
      end
      SUWx: begin
        if (lx_q != NilLink) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = XW'(lx_q) + XW'(1);
          mem_wdata_o = W'(lp_q);
        end
        if (n_q == XW'(head_q)) begin
          head_d = lx_q;
        end
        state_d = ret_q;
      end
      SPW1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = n_q + XW'(1);
        mem_wdata_o = W'(NilLink);
        state_d     = SPW2;
      end
      SPW2: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = n_q + XW'(2);
        mem_wdata_o = W'(head_q);
        state_d     = SPW3;
      end
      SPW3: begin
        if (head_q != NilLink) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = XW'(head_q) + XW'(1);
          mem_wdata_o = W'(n_q);
        end
        head_d  = LW'(n_q);
        state_d = ret_q;
      end
      SDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign in_stall_o = state_q != SIdle;
  assign res_item_o.status  = status_q;
  assign res_item_o.address = addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      ret_q   <= SIdle;
      init_q  <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      init_q  <= init_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    curv_q   <= curv_d;
    steps_q  <= steps_d;
    want_q   <= want_d;
    ex_q     <= ex_d;
    hdr_q    <= hdr_d;
    s_q      <= s_d;
    nx_q     <= nx_d;
    nxin_q   <= nxin_d;
    nxhdr_q  <= nxhdr_d;
    prv_q    <= prv_d;
    prvhdr_q <= prvhdr_d;
    wp_q     <= wp_d;
    wn_q     <= wn_d;
    nsz_q    <= nsz_d;
    base_q   <= base_d;
    foot_q   <= foot_d;
    n_q      <= n_d;
    lp_q     <= lp_d;
    lx_q     <= lx_d;
    status_q <= status_d;
    addr_q   <= addr_d;
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle && in_valid_i) |=> (state_q != SIdle))
    else $error("accepted item did not start work");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> !mem_we_o)
    else $error("heap written while idle");

  a_result_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> (state_q == SIdle))
    else $error("controller did not return to idle after result");

endmodule

`default_nettype wire
